// File: hdl/nrtp_pkg.sv
`default_nettype none

package nrtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_CW = 4;
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_FULL     = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_MISMATCH = 3'd3;
  localparam logic [2:0] ERR_OPEN     = 3'd4;

  localparam logic REG_FRAME_IDX = 1'b0;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       clear;
    logic       copy;
    logic       push;
    logic       accum;
    logic       pop;
    logic       cap_diff;
    logic       rd_frame;
    logic       cap_num;
    logic       div_init;
    logic       div_step;
    logic       set_err;
    logic [2:0] err;
  } nrtp_cmd_t;

  typedef struct packed {
    logic       sweep_last;
    logic       full;
    logic       empty;
    logic       top_match;
    logic       is_frame;
    logic [1:0] op;
    logic       depth_one;
    logic       div_skip;
    logic       div_last;
  } nrtp_stat_t;

endpackage

`default_nettype wire

// File: hdl/nested_region_time_profiler.sv
`default_nettype none

// Nested region stopwatch. Pulse start with an opcode (start, stop, query), a
// counter index and a timestamp while busy is low; exactly one result follows
// on error_code, frame_time, frame_fraction and open_depth, valid for the single
// cycle in which done is high. The receiver cannot stall, so sample on done.
// After reset the block clears both total banks with busy high. A query, a
// start or a rejected stop passes through decode, the snapshot reads and the
// serial fraction divider before done is raised, and a new request is taken
// only after done; the divider is skipped when the frame total is 0 or the
// counter total is at least the frame total. A matched stop adds a state to
// update the running total. Starting the frame counter adds a sweep that
// clears the running totals, and stopping it adds a sweep that copies them
// into the snapshot bank, one entry a cycle. frame_counter_index
// sits at address 0 of the register port and should be written only while busy
// is low.
module nested_region_time_profiler
  import nrtp_pkg::*;
#(
  parameter int NUM_COUNTERS = 16,
  parameter int STACK_DEPTH = 16,
  parameter int TIME_WIDTH = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         counter_id,
  input  wire logic [47:0]        timestamp,
  output logic                    done,
  output logic [2:0]              error_code,
  output logic [47:0]             frame_time,
  output logic [FRAC_BITS:0]      frame_fraction,
  output logic [4:0]              open_depth,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [3:0] frame_counter_index;
  nrtp_cmd_t  cmd;
  nrtp_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter_index <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_IDX)) begin
      frame_counter_index <= pwdata[3:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_IDX: prdata = {28'd0, frame_counter_index};
      default:       prdata = '0;
    endcase
  end

  nrtp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  nrtp_dp #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .STACK_DEPTH  (STACK_DEPTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (opcode),
    .counter_id     (counter_id),
    .timestamp      (timestamp),
    .frame_idx      (frame_counter_index),
    .stat           (stat),
    .error_code     (error_code),
    .frame_time     (frame_time),
    .frame_fraction (frame_fraction),
    .open_depth     (open_depth)
  );

endmodule

`default_nettype wire

// File: hdl/nrtp_ram.sv
`default_nettype none

module nrtp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/nrtp_ctrl.sv
`default_nettype none

module nrtp_ctrl
  import nrtp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire nrtp_stat_t stat,
  output nrtp_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_CLEAR   = 4'd3;
  localparam logic [3:0] S_ACC     = 4'd4;
  localparam logic [3:0] S_COPY    = 4'd5;
  localparam logic [3:0] S_DRAIN   = 4'd6;
  localparam logic [3:0] S_RDSNAP  = 4'd7;
  localparam logic [3:0] S_RDDEN   = 4'd8;
  localparam logic [3:0] S_DIVINIT = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.err = ERR_OK;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RDSNAP;
        case (stat.op)
          OP_START: begin
            if (stat.full) begin
              cmd.set_err = 1'b1;
              cmd.err = ERR_FULL;
            end else begin
              cmd.push = 1'b1;
              if (stat.is_frame) state_next = S_CLEAR;
            end
          end
          OP_STOP: begin
            if (stat.empty) begin
              cmd.set_err = 1'b1;
              cmd.err = ERR_EMPTY;
            end else if (!stat.top_match) begin
              cmd.set_err = 1'b1;
              cmd.err = ERR_MISMATCH;
            end else begin
              cmd.cap_diff = 1'b1;
              state_next = S_ACC;
            end
          end
          default: begin
            state_next = S_RDSNAP;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.sweep_last) state_next = S_RDSNAP;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        cmd.pop = 1'b1;
        state_next = S_RDSNAP;
        if (stat.is_frame) begin
          // snapshot is still taken when inner regions stay open
          if (!stat.depth_one) begin
            cmd.set_err = 1'b1;
            cmd.err = ERR_OPEN;
          end
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.sweep_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_RDSNAP;
      end
      S_RDSNAP: begin
        state_next = S_RDDEN;
      end
      S_RDDEN: begin
        cmd.cap_num = 1'b1;
        cmd.rd_frame = 1'b1;
        state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next = stat.div_skip ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

`default_nettype wire

// File: hdl/nrtp_dp.sv
`default_nettype none

module nrtp_dp
  import nrtp_pkg::*;
#(
  parameter int NUM_COUNTERS = 16,
  parameter int STACK_DEPTH = 16,
  parameter int TIME_WIDTH = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nrtp_cmd_t         cmd,
  input  wire logic [1:0]        opcode,
  input  wire logic [3:0]        counter_id,
  input  wire logic [47:0]       timestamp,
  input  wire logic [3:0]        frame_idx,
  output nrtp_stat_t             stat,
  output logic [2:0]             error_code,
  output logic [47:0]            frame_time,
  output logic [FRAC_BITS:0]     frame_fraction,
  output logic [4:0]             open_depth
);

  localparam int CW = $clog2(NUM_COUNTERS);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int TW = TIME_WIDTH;

  function automatic logic [CW-1:0] idx_mod(input logic [3:0] v);
    int r;
    r = int'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= NUM_COUNTERS) r = r - NUM_COUNTERS;
    end
    return CW'(r);
  endfunction

  logic [1:0]         op_q;
  logic [CW-1:0]      id_q;
  logic [CW-1:0]      frame_q;
  logic [TW-1:0]      ts_q;
  logic [DW-1:0]      depth;
  logic [2:0]         err_q;
  logic [TW-1:0]      diff_q;
  logic [TW-1:0]      num_q;
  logic [TW-1:0]      den_q;
  logic [TW-1:0]      rem_q;
  logic [FRAC_BITS:0] quo_q;
  logic [DIV_CW-1:0]  div_cnt;
  logic [CW-1:0]      cnt;
  logic               pend_q;
  logic [CW-1:0]      pend_addr;

  logic [TW+CW-1:0]   stk_rd;
  logic [TW-1:0]      top_time;
  logic [CW-1:0]      top_id;
  logic [TW-1:0]      run_rd;
  logic [TW-1:0]      snap_rd;
  logic [TW:0]        sum;
  logic [TW-1:0]      sat;
  logic [TW-1:0]      rem_gap;
  logic               rem_ge;
  logic               sweep;

  assign sweep = cmd.init | cmd.clear | cmd.copy;

  // stack: one entry holds start time and counter index
  nrtp_ram #(.WIDTH(TW + CW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (SAW'(depth)),
    .wdata ({ts_q, id_q}),
    .raddr (SAW'(depth - DW'(1))),
    .rdata (stk_rd)
  );

  assign top_time = stk_rd[TW+CW-1:CW];
  assign top_id   = stk_rd[CW-1:0];

  nrtp_ram #(.WIDTH(TW), .DEPTH(NUM_COUNTERS)) u_running (
    .clk   (clk),
    .we    (cmd.init | cmd.clear | cmd.accum),
    .waddr ((cmd.init | cmd.clear) ? cnt : id_q),
    .wdata (cmd.accum ? sat : '0),
    .raddr (cmd.copy ? cnt : id_q),
    .rdata (run_rd)
  );

  // copy runs one entry behind the running-total read
  nrtp_ram #(.WIDTH(TW), .DEPTH(NUM_COUNTERS)) u_snapshot (
    .clk   (clk),
    .we    (cmd.init | pend_q),
    .waddr (cmd.init ? cnt : pend_addr),
    .wdata (cmd.init ? '0 : run_rd),
    .raddr (cmd.rd_frame ? frame_q : id_q),
    .rdata (snap_rd)
  );

  assign sum = {1'b0, run_rd} + {1'b0, diff_q};
  assign sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  // r < den, so 2r >= den exactly when r >= den - r
  assign rem_gap = den_q - rem_q;
  assign rem_ge  = (rem_q >= rem_gap);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      cnt     <= '0;
      pend_q  <= 1'b0;
      err_q   <= ERR_OK;
      div_cnt <= '0;
    end else begin
      pend_q <= cmd.copy;
      if (sweep) begin
        cnt <= stat.sweep_last ? '0 : cnt + CW'(1);
      end
      if (cmd.push) begin
        depth <= depth + DW'(1);
      end else if (cmd.pop) begin
        depth <= depth - DW'(1);
      end
      if (cmd.load) begin
        err_q <= ERR_OK;
      end else if (cmd.set_err) begin
        err_q <= cmd.err;
      end
      if (cmd.div_init) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    if (cmd.load) begin
      op_q    <= opcode;
      id_q    <= idx_mod(counter_id);
      frame_q <= idx_mod(frame_idx);
      ts_q    <= TW'(timestamp);
    end
    if (cmd.cap_diff) begin
      diff_q <= ts_q - top_time;
    end
    if (cmd.cap_num) begin
      num_q <= snap_rd;
    end
    if (cmd.div_init) begin
      den_q <= snap_rd;
      rem_q <= num_q;
      if (snap_rd == '0) begin
        quo_q <= '0;
      end else if (num_q >= snap_rd) begin
        quo_q <= FRAC_ONE;
      end else begin
        quo_q <= '0;
      end
    end else if (cmd.div_step) begin
      quo_q <= {quo_q[FRAC_BITS-1:0], rem_ge};
      rem_q <= rem_ge ? (rem_q - rem_gap) : {rem_q[TW-2:0], 1'b0};
    end
  end

  always_comb begin
    stat.sweep_last = (cnt == CW'(NUM_COUNTERS - 1));
    stat.full       = (depth == DW'(STACK_DEPTH));
    stat.empty      = (depth == '0);
    stat.top_match  = (top_id == id_q);
    stat.is_frame   = (id_q == frame_q);
    stat.op         = op_q;
    stat.depth_one  = (depth == DW'(1));
    stat.div_skip   = (snap_rd == '0) || (num_q >= snap_rd);
    stat.div_last   = (div_cnt == DIV_CW'(FRAC_BITS - 1));
  end

  assign error_code     = err_q;
  assign frame_time     = 48'(num_q);
  assign frame_fraction = quo_q;
  assign open_depth     = 5'(depth);

endmodule

`default_nettype wire

// File: test/tb_nested_region_time_profiler.sv
`default_nettype none

module tb_nested_region_time_profiler;
  import nrtp_pkg::*;

  localparam int NUM_CTR = 16;
  localparam int STK_MAX = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] FRAME_IDX_ADDR = {REG_FRAME_IDX, 2'b00};
  localparam logic [47:0] TIME_MAX = '1;

  typedef struct {
    logic [2:0]  err;
    logic [47:0] ftime;
    logic [16:0] frac;
    logic [4:0]  depth;
  } report_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [3:0]  counter_id;
  logic [47:0] timestamp;
  logic        done;
  logic [2:0]  error_code;
  logic [47:0] frame_time;
  logic [16:0] frame_fraction;
  logic [4:0]  open_depth;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // profiler state as the predictor sees it
  logic [47:0] stk_ts [STK_MAX];
  logic [3:0]  stk_id [STK_MAX];
  int          open_regions;
  logic [47:0] run_acc [NUM_CTR];
  logic [47:0] snap_acc [NUM_CTR];
  logic [3:0]  frame_idx;

  report_t     report_q [$];
  int          mismatches;
  int          requests_sent;
  int          reports_seen;
  int          snapshots;
  int          err_seen [5];
  int          stall_cycles;
  int          burst_left;
  bit          gaps_on;
  logic [47:0] now_ts;

  nested_region_time_profiler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .counter_id(counter_id),
    .timestamp(timestamp),
    .done(done),
    .error_code(error_code),
    .frame_time(frame_time),
    .frame_fraction(frame_fraction),
    .open_depth(open_depth),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void check_field(input string what, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // unsigned Q1.16 share of part in whole, truncated, capped at 1.0
  function automatic logic [16:0] share_q16(input logic [47:0] part, input logic [47:0] whole);
    logic [63:0] scaled;
    if (whole == 48'd0) return 17'd0;
    if (part >= whole) return FRAC_ONE;
    scaled = {part, 16'h0000};
    scaled = scaled / {16'h0000, whole};
    return scaled[16:0];
  endfunction

  task automatic stopwatch_step(input logic [1:0] op, input logic [3:0] id,
                                input logic [47:0] ts);
    report_t     r;
    logic [47:0] span;
    r.err = ERR_OK;
    case (op)
      OP_START: begin
        if (open_regions >= STK_MAX) begin
          r.err = ERR_FULL;
        end else begin
          if (id == frame_idx)
            foreach (run_acc[i]) run_acc[i] = 48'd0;
          stk_ts[open_regions] = ts;
          stk_id[open_regions] = id;
          open_regions++;
        end
      end
      OP_STOP: begin
        if (open_regions == 0) begin
          r.err = ERR_EMPTY;
        end else if (stk_id[open_regions-1] != id) begin
          r.err = ERR_MISMATCH;
        end else begin
          span = ts - stk_ts[open_regions-1];
          open_regions--;
          run_acc[id] = (span > TIME_MAX - run_acc[id]) ? TIME_MAX : run_acc[id] + span;
          if (id == frame_idx) begin
            if (open_regions != 0) r.err = ERR_OPEN;
            snap_acc = run_acc;
            snapshots++;
          end
        end
      end
      default: begin
      end
    endcase
    r.ftime = snap_acc[id];
    r.frac = share_q16(snap_acc[id], snap_acc[frame_idx]);
    r.depth = 5'(open_regions);
    err_seen[r.err]++;
    report_q.push_back(r);
  endtask

  task automatic issue_request(input logic [1:0] op, input logic [3:0] id,
                               input logic [47:0] ts);
    start <= 1'b1;
    opcode <= op;
    counter_id <= id;
    timestamp <= ts;
    do @(posedge clk); while (busy);
    requests_sent++;
    stopwatch_step(op, id, ts);
    // start stays high inside a burst, the next request follows at once
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
        burst_left = $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_counter(input logic [3:0] idx);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = $urandom();
    wdata[3:0] = idx;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FRAME_IDX_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frame_idx = idx;
    // read back right after the write
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("frame_counter_index readback", {44'd0, idx}, {16'd0, rdata});
  endtask

  task automatic advance_clock();
    case ($urandom_range(0, 49))
      0: now_ts = now_ts + 48'({$urandom(), $urandom()});
      1: begin
      end
      default: now_ts = now_ts + 48'($urandom_range(1, 2000));
    endcase
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b1;
    issue_request(OP_QUERY, 4'd0, 48'd0);
    issue_request(OP_SPARE, 4'd15, TIME_MAX);
    issue_request(OP_STOP, 4'd4, 48'd50);
    issue_request(OP_START, 4'd0, 48'd100);
    issue_request(OP_START, 4'd5, 48'd200);
    issue_request(OP_STOP, 4'd7, 48'd250);
    issue_request(OP_STOP, 4'd5, 48'd300);
    issue_request(OP_STOP, 4'd0, 48'd1000);
    issue_request(OP_QUERY, 4'd5, 48'd1001);
    // saturation inside a frame that closes with a region still open
    issue_request(OP_START, 4'd9, 48'd2000);
    issue_request(OP_START, 4'd0, 48'd2100);
    issue_request(OP_START, 4'd3, 48'd0);
    issue_request(OP_STOP, 4'd3, TIME_MAX);
    issue_request(OP_START, 4'd3, 48'd1);
    issue_request(OP_STOP, 4'd3, 48'd0);
    issue_request(OP_STOP, 4'd0, 48'd2105);
    issue_request(OP_QUERY, 4'd3, 48'h5555_5555_5555);
    issue_request(OP_STOP, 4'd9, 48'd5000);
    // frame across the timestamp wrap
    issue_request(OP_START, 4'd0, 48'hFFFF_FFFF_FFF0);
    issue_request(OP_STOP, 4'd0, 48'h0000_0000_0010);
    issue_request(OP_QUERY, 4'd9, 48'hAAAA_AAAA_AAAA);
    issue_request(OP_QUERY, 4'd0, 48'd7);
    settle();
  endtask

  task automatic test_stack_bounds();
    logic [3:0] top;
    gaps_on = 1'b1;
    set_frame_counter(4'd15);
    now_ts = 48'({$urandom(), $urandom()});
    issue_request(OP_START, 4'd15, now_ts);
    for (int i = 1; i < STK_MAX; i++) begin
      advance_clock();
      issue_request(OP_START, 4'($urandom_range(0, 14)), now_ts);
    end
    // full stack: the frame start must not clear anything
    issue_request(OP_START, 4'd15, now_ts + 48'd3);
    issue_request(OP_START, 4'd2, now_ts + 48'd4);
    top = stk_id[open_regions-1];
    issue_request(OP_STOP, top ^ 4'd1, now_ts + 48'd5);
    while (open_regions > 0) begin
      advance_clock();
      issue_request(OP_STOP, stk_id[open_regions-1], now_ts);
    end
    issue_request(OP_STOP, 4'd15, now_ts);
    issue_request(OP_QUERY, 4'd15, now_ts);
    issue_request(OP_QUERY, 4'($urandom_range(0, 14)), now_ts);
    settle();
  endtask

  task automatic test_nested_frames(input logic [3:0] idx, input int n_items,
                                    input bit with_gaps);
    logic [1:0] op;
    logic [3:0] id;
    logic [47:0] ts;
    int pick;
    gaps_on = with_gaps;
    set_frame_counter(idx);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      advance_clock();
      ts = now_ts;
      id = 4'($urandom_range(0, 15));
      if (pick < 10) begin
        // noise: anything goes
        op = 2'($urandom_range(0, 3));
        ts = 48'({$urandom(), $urandom()});
      end else if (open_regions == 0) begin
        op = (pick < 85) ? OP_START : OP_QUERY;
        if (pick < 85) id = frame_idx;
      end else if (pick < 52) begin
        op = OP_START;
      end else if (pick < 90) begin
        op = OP_STOP;
        if (pick < 87) id = stk_id[open_regions-1];
      end else begin
        op = OP_QUERY;
      end
      issue_request(op, id, ts);
    end
    // close any regions left so the next phase starts clean
    while (open_regions > 0) begin
      advance_clock();
      issue_request(OP_STOP, stk_id[open_regions-1], now_ts);
    end
    settle();
  endtask

  always @(posedge clk) begin : report_check
    report_t want;
    if (!rst && done) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none, got error_code %0d frame_time 0x%0h",
                 $time, error_code, frame_time);
      end else begin
        want = report_q.pop_front();
        check_field("error_code", {45'd0, want.err}, {45'd0, error_code});
        check_field("frame_time", want.ftime, frame_time);
        check_field("frame_fraction", {31'd0, want.frac}, {31'd0, frame_fraction});
        check_field("open_depth", {43'd0, want.depth}, {43'd0, open_depth});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    opcode <= OP_START;
    counter_id <= 4'd0;
    timestamp <= 48'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FRAME_IDX_ADDR;
    pwdata <= 32'd0;
    foreach (stk_ts[i]) stk_ts[i] = 48'd0;
    foreach (stk_id[i]) stk_id[i] = 4'd0;
    foreach (run_acc[i]) run_acc[i] = 48'd0;
    foreach (snap_acc[i]) snap_acc[i] = 48'd0;
    foreach (err_seen[i]) err_seen[i] = 0;
    open_regions = 0;
    frame_idx = 4'd0;
    mismatches = 0;
    requests_sent = 0;
    reports_seen = 0;
    snapshots = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    now_ts = 48'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_stack_bounds();
    test_nested_frames(4'd15, 200, 1'b1);
    test_nested_frames(4'd0, 200, 1'b0);
    test_nested_frames(4'($urandom_range(1, 14)), 200, 1'b1);

    $display("covered %0d requests and %0d reports over %0d frame snapshots",
             requests_sent, reports_seen, snapshots);
    $display("status counts: ok %0d, full %0d, empty %0d, mismatch %0d, open %0d",
             err_seen[ERR_OK], err_seen[ERR_FULL], err_seen[ERR_EMPTY],
             err_seen[ERR_MISMATCH], err_seen[ERR_OPEN]);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
